/* rtl/i2a_pkg.sv */
// shared types, constants and helpers for the integer to ascii formatter
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_W    = 64;
    localparam int CNT_W      = 7;
    localparam int ND_W       = 5;
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int HEX_DIGITS = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef enum logic [1:0] {
        MODE_SDEC = 2'd0,
        MODE_UDEC = 2'd1,
        MODE_LHEX = 2'd2,
        MODE_UHEX = 2'd3
    } t_mode;

    typedef struct packed {
        logic               hex;
        logic               upper;
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [CNT_W-1:0]   width;
        logic               zero_fill;
        logic               flush_left;
        logic [CNT_W-1:0]   lim;
    } t_item;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'h0, d};
        end else if (upper) begin
            c = 8'h41 + {4'h0, d - 4'd10};
        end else begin
            c = 8'h61 + {4'h0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

/* rtl/integer_to_ascii_formatter.sv */
// top level of the integer to ascii formatter
`timescale 1ns / 1ps

// Formats one 64-bit integer per input transaction as printf-style text.
// Input channel: i_valid / o_stall with mode, value, width, zero_fill,
// flush_left and room. Output channel: o_valid / i_stall, one transaction
// per character, most significant first, o_last on the final one. A room
// of zero gives a single transaction with o_has_char low and o_last high.
// Up to two transactions wait in a queue between the front end and the
// conversion engine, so the input keeps taking work while text drains.
// Decimal modes: double-dabble conversion, two bits per cycle, then
// stripping of up to 19 leading zero digits. Hex modes skip the
// double-dabble and only strip leading zero digits, up to 15 of them.
// After that one character per cycle while i_stall is low; a stalled
// character is held in the output register until taken.
// Reset is synchronous; it empties the queue and drops any pending output.
module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int MAX_CHARS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [CNT_W-1:0]   i_width,
    input  logic               i_zero_fill,
    input  logic               i_flush_left,
    input  logic [CNT_W-1:0]   i_room,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_character,
    output logic               o_has_char,
    output logic               o_last
);

    logic  q_full;
    logic  q_push;
    t_item q_in;
    logic  q_pop;
    logic  q_valid;
    t_item q_out;

    i2a_front #(
        .MAX_CHARS(MAX_CHARS)
    ) u_front (
        .i_valid      (i_valid),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_width      (i_width),
        .i_zero_fill  (i_zero_fill),
        .i_flush_left (i_flush_left),
        .i_room       (i_room),
        .i_q_full     (q_full),
        .o_stall      (o_stall),
        .o_push       (q_push),
        .o_item       (q_in)
    );

    i2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    i2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_has_char  (o_has_char),
        .o_last      (o_last)
    );

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_char |-> o_last && (o_character == CH_NONE))
        else $error("empty transaction not marked last");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_char |->
            ((o_character >= 8'h30) && (o_character <= 8'h39)) ||
            ((o_character >= 8'h41) && (o_character <= 8'h46)) ||
            ((o_character >= 8'h61) && (o_character <= 8'h66)) ||
            (o_character == CH_SPACE) || (o_character == CH_MINUS))
        else $error("character outside the output set");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

/* rtl/i2a_front.sv */
// front end: takes input transactions and classifies them into queue entries
`timescale 1ns / 1ps

module i2a_front
    import i2a_pkg::*;
#(
    parameter int MAX_CHARS = 64
) (
    input  logic               i_valid,
    input  logic [1:0]         i_mode,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [CNT_W-1:0]   i_width,
    input  logic               i_zero_fill,
    input  logic               i_flush_left,
    input  logic [CNT_W-1:0]   i_room,
    input  logic               i_q_full,
    output logic               o_stall,
    output logic               o_push,
    output t_item              o_item
);

    t_mode mode;
    logic  neg;

    assign mode    = t_mode'(i_mode);
    assign neg     = (mode == MODE_SDEC) && i_value[VALUE_W-1];
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item            = '0;
        o_item.hex        = (mode == MODE_LHEX) || (mode == MODE_UHEX);
        o_item.upper      = (mode == MODE_UHEX);
        o_item.neg        = neg;
        o_item.mag        = neg ? (~i_value + VALUE_W'(1)) : i_value;
        o_item.width      = i_width;
        o_item.zero_fill  = i_zero_fill && !i_flush_left;
        o_item.flush_left = i_flush_left;
        o_item.lim        = (32'(i_room) < MAX_CHARS) ? i_room : CNT_W'(MAX_CHARS);
    end

endmodule

/* rtl/i2a_queue.sv */
// two-entry queue between the front end and the back end
`timescale 1ns / 1ps

module i2a_queue
    import i2a_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_data
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* rtl/i2a_back.sv */
// back end: digit conversion, digit count and character emission
`timescale 1ns / 1ps

module i2a_back
    import i2a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_character,
    output logic       o_has_char,
    output logic       o_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic               r_upper;
    logic               r_neg;
    logic [CNT_W-1:0]   r_width;
    logic               r_zp;
    logic               r_la;
    logic [CNT_W-1:0]   r_lim;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [4:0]         r_step;
    logic [ND_W-1:0]    r_nd;
    logic [CNT_W-1:0]   r_pad;
    logic               r_sign;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_has;
    logic               r_last;

    logic             out_free;
    logic [BCD_W-1:0] dd_next;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] pad;
    logic [7:0]       flen;
    logic [CNT_W-1:0] n_count;
    logic             pre_sp;
    logic             use_zero;
    logic [7:0]       sel_char;
    logic             top_zero;

    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b, input logic bit_in);
        logic [BCD_W-1:0] a;
        a = b;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (a[4*k +: 4] >= 4'd5) begin
                a[4*k +: 4] = a[4*k +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign dd_next  = dd_step(dd_step(r_bcd, r_bin[VALUE_W-1]), r_bin[VALUE_W-2]);
    assign top_zero = (r_bcd[BCD_W-1 -: 4] == 4'h0);

    assign total   = CNT_W'(r_nd) + CNT_W'(r_neg);
    assign pad     = (r_width > total) ? (r_width - total) : '0;
    assign flen    = 8'(pad) + 8'(total);
    assign n_count = (8'(r_lim) < flen) ? r_lim : CNT_W'(flen);

    assign pre_sp   = !r_la && !r_zp && (r_pad != '0);
    assign use_zero = r_zp && (r_pad != '0);

    always_comb begin
        if (pre_sp) begin
            sel_char = CH_SPACE;
        end else if (r_sign) begin
            sel_char = CH_MINUS;
        end else if (use_zero) begin
            sel_char = CH_ZERO;
        end else if (r_nd != '0) begin
            sel_char = digit_char(r_bcd[BCD_W-1 -: 4], r_upper);
        end else begin
            sel_char = CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_upper <= i_q_item.upper;
                        r_neg   <= i_q_item.neg;
                        r_width <= i_q_item.width;
                        r_zp    <= i_q_item.zero_fill;
                        r_la    <= i_q_item.flush_left;
                        r_lim   <= i_q_item.lim;
                        r_bin   <= i_q_item.mag;
                        r_step  <= '0;
                        if (i_q_item.lim == '0) begin
                            r_state <= ST_EMIT;
                        end else if (i_q_item.hex) begin
                            r_bcd   <= {i_q_item.mag, {(BCD_W-VALUE_W){1'b0}}};
                            r_nd    <= ND_W'(HEX_DIGITS);
                            r_state <= ST_NORM;
                        end else begin
                            r_bcd   <= '0;
                            r_nd    <= ND_W'(BCD_DIGITS);
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    r_bcd  <= dd_next;
                    r_bin  <= {r_bin[VALUE_W-3:0], 2'b00};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if ((r_nd > ND_W'(1)) && top_zero) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'h0};
                        r_nd  <= r_nd - ND_W'(1);
                    end else begin
                        r_pad   <= pad;
                        r_sign  <= r_neg;
                        r_n     <= n_count;
                        r_cnt   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_lim == '0) begin
                            r_char  <= CH_NONE;
                            r_has   <= 1'b0;
                            r_last  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_char <= sel_char;
                            r_has  <= 1'b1;
                            r_last <= (r_cnt == r_n - CNT_W'(1));
                            r_cnt  <= r_cnt + CNT_W'(1);
                            if (pre_sp) begin
                                r_pad <= r_pad - CNT_W'(1);
                            end else if (r_sign) begin
                                r_sign <= 1'b0;
                            end else if (use_zero) begin
                                r_pad <= r_pad - CNT_W'(1);
                            end else if (r_nd != '0) begin
                                r_bcd <= {r_bcd[BCD_W-5:0], 4'h0};
                                r_nd  <= r_nd - ND_W'(1);
                            end else begin
                                r_pad <= r_pad - CNT_W'(1);
                            end
                            if (r_cnt == r_n - CNT_W'(1)) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_has_char  = r_has;
    assign o_last      = r_last;

endmodule

/* dv/i2a_text_checker.sv */
// channel monitor, character predictor and comparator for the integer to ascii formatter
`timescale 1ns / 1ps

module i2a_text_checker
    import i2a_pkg::*;
#(
    parameter int MAX_CHARS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [CNT_W-1:0]   i_width,
    input  logic               i_zero_fill,
    input  logic               i_flush_left,
    input  logic [CNT_W-1:0]   i_room,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [7:0]         i_character,
    input  logic               i_has_char,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_chars_checked
);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam int         MAX_DIGITS = 24;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } t_char_result;

    t_char_result expected_chars[$];
    t_char_result want;
    int           fail_total;
    int           checked_total;

    function automatic void format_text(
        input t_mode              mode,
        input logic [VALUE_W-1:0] value,
        input logic [CNT_W-1:0]   width,
        input logic               zero_fill,
        input logic               flush_left,
        input logic [CNT_W-1:0]   room
    );
        int                 lim;
        int                 nd;
        int                 total;
        int                 pad;
        int                 k;
        logic               neg;
        logic               upper;
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] base;
        logic [3:0]         d;
        logic [7:0]         rev[MAX_DIGITS];
        logic [7:0]         text[$];
        t_char_result       r;

        lim = (int'(room) < MAX_CHARS) ? int'(room) : MAX_CHARS;
        if (lim == 0) begin
            r = '{ch: CH_NONE, has_char: 1'b0, last: 1'b1};
            expected_chars.push_back(r);
            return;
        end

        upper = (mode == MODE_UHEX);
        base  = (mode == MODE_LHEX || mode == MODE_UHEX) ? 64'd16 : 64'd10;
        neg   = (mode == MODE_SDEC) && value[VALUE_W-1];
        mag   = neg ? (64'd0 - value) : value;

        nd = 0;
        do begin
            d = 4'(mag % base);
            if (d < 4'd10) begin
                rev[nd] = CH_ZERO + 8'(d);
            end else begin
                rev[nd] = (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
            end
            nd++;
            mag = mag / base;
        end while (mag != 0 && nd < MAX_DIGITS);

        total = nd + (neg ? 1 : 0);
        pad   = (int'(width) > total) ? int'(width) - total : 0;

        if (!flush_left && !zero_fill) begin
            for (k = 0; k < pad && text.size() < lim; k++) text.push_back(CH_SPACE);
        end
        if (neg && text.size() < lim) begin
            text.push_back(CH_MINUS);
        end
        if (!flush_left && zero_fill) begin
            for (k = 0; k < pad && text.size() < lim; k++) text.push_back(CH_ZERO);
        end
        for (k = nd; k > 0 && text.size() < lim; k--) text.push_back(rev[k-1]);
        if (flush_left) begin
            for (k = 0; k < pad && text.size() < lim; k++) text.push_back(CH_SPACE);
        end

        for (k = 0; k < text.size(); k++) begin
            r = '{ch: text[k], has_char: 1'b1, last: (k == text.size() - 1)};
            expected_chars.push_back(r);
        end
    endfunction

    initial begin
        fail_total    = 0;
        checked_total = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_chars.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                format_text(t_mode'(i_mode), i_value, i_width, i_zero_fill, i_flush_left,
                            i_room);
            end
            if (i_out_valid && !i_out_stall) begin
                checked_total++;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h %b %b",
                             $time, i_character, i_has_char, i_last);
                    fail_total++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_character !== want.ch) begin
                        $display("%0t: character mismatch, expected %h actual %h",
                                 $time, want.ch, i_character);
                        fail_total++;
                    end
                    if (i_has_char !== want.has_char) begin
                        $display("%0t: has_char mismatch, expected %b actual %b",
                                 $time, want.has_char, i_has_char);
                        fail_total++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want.last, i_last);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= expected_chars.size();
        o_chars_checked <= checked_total;
    end

endmodule

/* dv/tb_integer_to_ascii_formatter.sv */
// top-level testbench for the integer to ascii formatter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;
    import i2a_pkg::*;

    localparam int MAX_CHARS      = 64;
    localparam int NUM_RANDOM     = 405;
    localparam int CALM_ITEMS     = 60;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    localparam logic [VALUE_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_mode;
    logic [VALUE_W-1:0] i_value;
    logic [CNT_W-1:0]   i_width;
    logic               i_zero_fill;
    logic               i_flush_left;
    logic [CNT_W-1:0]   i_room;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_character;
    logic               o_has_char;
    logic               o_last;

    int   fail_count;
    int   pending;
    int   chars_checked;
    int   items_sent;
    int   idle_cycles;
    logic quiet;
    logic hold_done;

    integer_to_ascii_formatter #(
        .MAX_CHARS(MAX_CHARS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_width     (i_width),
        .i_zero_fill (i_zero_fill),
        .i_flush_left(i_flush_left),
        .i_room      (i_room),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_has_char  (o_has_char),
        .o_last      (o_last)
    );

    i2a_text_checker #(
        .MAX_CHARS(MAX_CHARS)
    ) u_text_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .i_width        (i_width),
        .i_zero_fill    (i_zero_fill),
        .i_flush_left   (i_flush_left),
        .i_room         (i_room),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_character    (o_character),
        .i_has_char     (o_has_char),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_chars_checked(chars_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(
        input t_mode              mode,
        input logic [VALUE_W-1:0] value,
        input logic [CNT_W-1:0]   width,
        input logic               zero_fill,
        input logic               flush_left,
        input logic [CNT_W-1:0]   room
    );
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_value      <= value;
        i_width      <= width;
        i_zero_fill  <= zero_fill;
        i_flush_left <= flush_left;
        i_room       <= room;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int                 k;
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 999));
            1: v = {$urandom, $urandom};
            2: v = 64'd0 - 64'($urandom_range(1, 100000));
            3: begin
                p = 64'd1;
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                v = p - 64'($urandom_range(0, 1));
            end
            4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 64'd0;
                    1: v = ALL_ONES;
                    2: v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] pick_room();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 7'd0;
        if (sel == 1) return CNT_W'($urandom_range(65, 127));
        if (sel <= 3) return CNT_W'($urandom_range(1, 20));
        if (sel <= 6) return 7'd64;
        return CNT_W'($urandom_range(21, 64));
    endfunction

    // sender: directed cases, then random mix
    initial begin
        logic [CNT_W-1:0] w;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_mode       <= MODE_SDEC;
        i_value      <= '0;
        i_width      <= '0;
        i_zero_fill  <= 1'b0;
        i_flush_left <= 1'b0;
        i_room       <= '0;
        items_sent = 0;
        quiet      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(MODE_SDEC, 64'd0,            7'd0,   1'b0, 1'b0, 7'd64);
        send_item(MODE_SDEC, MOST_NEG,         7'd0,   1'b0, 1'b0, 7'd64);
        send_item(MODE_SDEC, ALL_ONES,         7'd0,   1'b0, 1'b0, 7'd64);
        send_item(MODE_SDEC, MOST_POS,         7'd0,   1'b0, 1'b0, 7'd64);
        send_item(MODE_UDEC, ALL_ONES,         7'd0,   1'b0, 1'b0, 7'd64);
        send_item(MODE_UDEC, 64'd10_000_000_000_000_000_000, 7'd0, 1'b0, 1'b0, 7'd64);
        send_item(MODE_LHEX, ALL_ONES,         7'd0,   1'b0, 1'b0, 7'd64);
        send_item(MODE_UHEX, 64'hDEAD_BEEF_CAFE_F00D, 7'd0, 1'b0, 1'b0, 7'd64);
        send_item(MODE_LHEX, 64'hDEAD_BEEF_CAFE_F00D, 7'd0, 1'b0, 1'b0, 7'd64);
        send_item(MODE_UDEC, 64'd12345,        7'd0,   1'b0, 1'b0, 7'd0);
        send_item(MODE_SDEC, 64'd0 - 64'd9,    7'd64,  1'b1, 1'b0, 7'd0);
        send_item(MODE_SDEC, 64'd42,           7'd64,  1'b0, 1'b0, 7'd64);
        send_item(MODE_SDEC, 64'd0 - 64'd42,   7'd64,  1'b1, 1'b0, 7'd64);
        send_item(MODE_UDEC, 64'd123,          7'd30,  1'b0, 1'b1, 7'd64);
        send_item(MODE_SDEC, 64'd0 - 64'd123,  7'd30,  1'b1, 1'b1, 7'd64);
        send_item(MODE_SDEC, 64'd0 - 64'd5,    7'd127, 1'b0, 1'b0, 7'd127);
        send_item(MODE_UDEC, ALL_ONES,         7'd0,   1'b0, 1'b0, 7'd3);
        send_item(MODE_SDEC, 64'd0 - 64'd77,   7'd0,   1'b0, 1'b0, 7'd1);
        send_item(MODE_UHEX, 64'hABC,          7'd127, 1'b1, 1'b0, 7'd64);
        send_item(MODE_SDEC, 64'd0 - 64'd7,    7'd5,   1'b1, 1'b0, 7'd64);
        send_item(MODE_LHEX, 64'd0,            7'd8,   1'b1, 1'b0, 7'd64);
        send_item(MODE_UDEC, 64'd99,           7'd100, 1'b0, 1'b1, 7'd64);
        send_item(MODE_SDEC, MOST_NEG,         7'd25,  1'b1, 1'b0, 7'd10);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            quiet = (n >= NUM_RANDOM - CALM_ITEMS);
            w = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 127))
                                            : CNT_W'($urandom_range(0, 24));
            send_item(t_mode'($urandom_range(0, 3)), pick_value(), w,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_room());
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d values formatted in all modes, flags, widths and limits; %0d chars compared",
                 items_sent, chars_checked);
        $display("run included zero room, saturated output and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // receiver: random stall bursts, one long hold-off, none at the end
    initial begin
        int cnt;
        logic stall_now;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                stall_now = 1'b1;
                cnt       = HOLD_CYCLES;
            end else if (quiet) begin
                stall_now = 1'b0;
                cnt       = 1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_now = 1'b1;
                cnt       = $urandom_range(1, 9);
            end else begin
                stall_now = 1'b0;
                cnt       = $urandom_range(1, 12);
            end
            i_stall <= stall_now;
            repeat (cnt) @(posedge i_clk);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
